// ===== src/dpq_pkg.sv =====
// ----------------------------------------------------------------------------
// dpq_pkg
// Shared types and constants for the double-ended priority queue.
// ----------------------------------------------------------------------------
package dpq_pkg;

  localparam int CAPACITY   = 64;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int DATA_W     = 32;
  localparam int GROUPS     = 8;
  localparam int GROUP_SIZE = (CAPACITY + GROUPS - 1) / GROUPS;

  localparam logic [1:0] REQ_INSERT     = 2'd0;
  localparam logic [1:0] REQ_REMOVE_MAX = 2'd1;
  localparam logic [1:0] REQ_REMOVE_MIN = 2'd2;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] max_value;
    logic signed [DATA_W-1:0] min_value;
    logic [CNT_W-1:0]         entry_count;
    logic                     is_empty;
    logic [1:0]               status;
  } out_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                     ins;
    logic                     del_min;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         count;
  } ctrl_t;

endpackage

// ===== src/dpq_cell.sv =====
// ----------------------------------------------------------------------------
// dpq_cell
// One cell of the sorted chain: holds a value, shifts up on insert and down
// on removal of the minimum.
// ----------------------------------------------------------------------------
module dpq_cell (
  input  logic                             clk,
  input  dpq_pkg::ctrl_t                   ctrl,
  input  logic [dpq_pkg::CNT_W-1:0]        cell_idx,
  input  logic signed [dpq_pkg::DATA_W-1:0] left_val,
  input  logic                             left_gt,
  input  logic signed [dpq_pkg::DATA_W-1:0] right_val,
  output logic signed [dpq_pkg::DATA_W-1:0] cell_val,
  output logic                             cell_gt,
  output logic signed [dpq_pkg::DATA_W-1:0] top_val
);

  logic signed [dpq_pkg::DATA_W-1:0] val_r;
  logic signed [dpq_pkg::DATA_W-1:0] val_nxt;
  logic                              occupied;
  logic                              is_top;

  assign occupied = cell_idx < ctrl.count;
  assign cell_gt  = occupied && (ctrl.value < val_r);
  assign is_top   = cell_idx == (ctrl.count - dpq_pkg::CNT_W'(1));
  assign cell_val = val_r;
  assign top_val  = is_top ? val_r : '0;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins) begin
      if (left_gt) begin
        val_nxt = left_val;
      end else if (cell_gt || cell_idx == ctrl.count) begin
        val_nxt = ctrl.value;
      end
    end else if (ctrl.del_min) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== src/dpq_tree.sv =====
// ----------------------------------------------------------------------------
// dpq_tree
// Registered or-tree that picks the one non-zero top value out of the chain.
// ----------------------------------------------------------------------------
module dpq_tree (
  input  logic                                            clk,
  input  logic                                            capture,
  input  logic [dpq_pkg::CAPACITY-1:0][dpq_pkg::DATA_W-1:0] vals,
  output logic signed [dpq_pkg::DATA_W-1:0]                tree_or
);

  logic [dpq_pkg::GROUPS-1:0][dpq_pkg::DATA_W-1:0] grp_r;
  logic [dpq_pkg::GROUPS-1:0][dpq_pkg::DATA_W-1:0] grp_nxt;

  always_comb begin
    logic [dpq_pkg::DATA_W-1:0] acc;
    for (int g = 0; g < dpq_pkg::GROUPS; g++) begin
      acc = '0;
      for (int k = 0; k < dpq_pkg::GROUP_SIZE; k++) begin
        if (g * dpq_pkg::GROUP_SIZE + k < dpq_pkg::CAPACITY) begin
          acc = acc | vals[g * dpq_pkg::GROUP_SIZE + k];
        end
      end
      grp_nxt[g] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      grp_r <= grp_nxt;
    end
  end

  always_comb begin
    logic [dpq_pkg::DATA_W-1:0] acc2;
    acc2 = '0;
    for (int g = 0; g < dpq_pkg::GROUPS; g++) begin
      acc2 = acc2 | grp_r[g];
    end
    tree_or = $signed(acc2);
  end

endmodule

// ===== src/double_ended_priority_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Bounded min/max queue of signed values kept as a sorted chain of cells.
// ----------------------------------------------------------------------------
//  channel | direction | payload        | handshake
//  in_     | input     | dpq_pkg::in_t  | in_valid / in_ready
//  out_    | output    | dpq_pkg::out_t | out_valid / out_ready
//
//  each request passes a chain update, a group or, and a final or of the top
//  value into the output register
//  the chain updates all cells in the accept cycle; the or-tree sets the rest
//  a new request is taken while the previous result waits in the output register
//  a stalled output holds the block in its last step until out_ready
//  rst_n (synchronous) empties the queue; cell contents are not cleared
// ----------------------------------------------------------------------------
module double_ended_priority_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dpq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dpq_pkg::out_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_GATHER = 3'b010,
    ST_MERGE  = 3'b100
  } state_t;

  state_t                   state_r, state_nxt;
  logic [dpq_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [1:0]               status_r, status_nxt;
  dpq_pkg::out_t            out_r, out_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic                     in_fire;
  logic                     is_full;
  logic                     is_zero;
  logic                     out_load;
  dpq_pkg::ctrl_t           ctrl;

  logic signed [dpq_pkg::DATA_W-1:0]                  cval [dpq_pkg::CAPACITY];
  logic                                               cgt  [dpq_pkg::CAPACITY];
  logic [dpq_pkg::CAPACITY-1:0][dpq_pkg::DATA_W-1:0]  tops;
  logic signed [dpq_pkg::DATA_W-1:0]                  max_val;

  assign in_ready = state_r == ST_IDLE;
  assign in_fire  = in_valid && in_ready;
  assign is_full  = count_r == dpq_pkg::CNT_W'(dpq_pkg::CAPACITY);
  assign is_zero  = count_r == '0;
  assign out_load = (state_r == ST_MERGE) && (!out_valid_r || out_ready);

  always_comb begin
    ctrl.ins     = in_fire && in_data.req_type == dpq_pkg::REQ_INSERT && !is_full;
    ctrl.del_min = in_fire && in_data.req_type == dpq_pkg::REQ_REMOVE_MIN && !is_zero;
    ctrl.value   = in_data.value;
    ctrl.count   = count_r;
  end

  // sorted chain, smallest in cell 0
  for (genvar i = 0; i < dpq_pkg::CAPACITY; i++) begin : g_cell
    logic signed [dpq_pkg::DATA_W-1:0] lv;
    logic                              lg;
    logic signed [dpq_pkg::DATA_W-1:0] rv;
    if (i == 0) begin : g_first
      assign lv = '0;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = cval[i-1];
      assign lg = cgt[i-1];
    end
    if (i == dpq_pkg::CAPACITY - 1) begin : g_last
      assign rv = cval[i];
    end else begin : g_inner
      assign rv = cval[i+1];
    end
    dpq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cell_idx  (dpq_pkg::CNT_W'(i)),
      .left_val  (lv),
      .left_gt   (lg),
      .right_val (rv),
      .cell_val  (cval[i]),
      .cell_gt   (cgt[i]),
      .top_val   (tops[i])
    );
  end

  dpq_tree u_tree (
    .clk     (clk),
    .capture (state_r == ST_GATHER),
    .vals    (tops),
    .tree_or (max_val)
  );

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt  = ST_GATHER;
          status_nxt = dpq_pkg::STAT_DONE;
          case (in_data.req_type)
            dpq_pkg::REQ_INSERT: begin
              if (is_full) begin
                status_nxt = dpq_pkg::STAT_FULL;
              end else begin
                count_nxt = count_r + dpq_pkg::CNT_W'(1);
              end
            end
            dpq_pkg::REQ_REMOVE_MAX, dpq_pkg::REQ_REMOVE_MIN: begin
              if (is_zero) begin
                status_nxt = dpq_pkg::STAT_EMPTY;
              end else begin
                count_nxt = count_r - dpq_pkg::CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_GATHER: begin
        state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt       = 1'b1;
      out_nxt.max_value   = max_val;
      out_nxt.min_value   = is_zero ? '0 : cval[0];
      out_nxt.entry_count = count_r;
      out_nxt.is_empty    = is_zero;
      out_nxt.status      = status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      status_r    <= dpq_pkg::STAT_DONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= dpq_pkg::CNT_W'(dpq_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_full_drop : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.req_type == dpq_pkg::REQ_INSERT && is_full
    |=> status_r == dpq_pkg::STAT_FULL && $stable(count_r))
    else $error("insert into full queue not dropped");

  a_empty_ignore : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_zero && (in_data.req_type == dpq_pkg::REQ_REMOVE_MAX ||
    in_data.req_type == dpq_pkg::REQ_REMOVE_MIN)
    |=> status_r == dpq_pkg::STAT_EMPTY && count_r == '0)
    else $error("removal on empty queue not ignored");

  a_out_load : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == ST_IDLE)
    else $error("result not presented after merge");

  a_empty_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.is_empty == (out_r.entry_count == '0))
    else $error("empty flag disagrees with count");

endmodule
